>>> design/vdd_pkg.sv
`timescale 1ns / 1ps

package vdd_pkg;

	localparam logic [7:0] ESC_BYTE = 8'h19;

	// diacritic marks
	localparam logic [7:0] MARK_GRAVE = 8'h41;
	localparam logic [7:0] MARK_ACUTE = 8'h42;
	localparam logic [7:0] MARK_CIRC  = 8'h43;
	localparam logic [7:0] MARK_DIAER = 8'h48;
	localparam logic [7:0] MARK_CEDIL = 8'h4B;

	// base letters
	localparam logic [7:0] LET_A = 8'h61;
	localparam logic [7:0] LET_C = 8'h63;
	localparam logic [7:0] LET_E = 8'h65;
	localparam logic [7:0] LET_I = 8'h69;
	localparam logic [7:0] LET_O = 8'h6F;
	localparam logic [7:0] LET_U = 8'h75;

	// held escape bytes
	localparam logic [1:0] HELD_NONE = 2'd0;
	localparam logic [1:0] HELD_ESC  = 2'd1;
	localparam logic [1:0] HELD_MARK = 2'd2;
	localparam logic [1:0] HELD_BAD  = 2'd3;

	localparam int RES_MAX   = 3;
	localparam int QDEPTH    = 4;
	localparam int RES_W     = $clog2(RES_MAX + 1);
	localparam int CNT_W     = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       text_end;
	} res_t;

	// returns {hit, latin-1 code}
	function automatic logic [8:0] accent_lookup(input logic [7:0] mark,
		input logic [7:0] base);
		logic [8:0] r;
		r = 9'd0;
		case ({mark, base})
			{MARK_GRAVE, LET_A}: r = {1'b1, 8'hE0};
			{MARK_CIRC,  LET_A}: r = {1'b1, 8'hE2};
			{MARK_DIAER, LET_A}: r = {1'b1, 8'hE4};
			{MARK_GRAVE, LET_E}: r = {1'b1, 8'hE8};
			{MARK_ACUTE, LET_E}: r = {1'b1, 8'hE9};
			{MARK_CIRC,  LET_E}: r = {1'b1, 8'hEA};
			{MARK_DIAER, LET_E}: r = {1'b1, 8'hEB};
			{MARK_CIRC,  LET_I}: r = {1'b1, 8'hEE};
			{MARK_DIAER, LET_I}: r = {1'b1, 8'hEF};
			{MARK_CIRC,  LET_O}: r = {1'b1, 8'hF4};
			{MARK_DIAER, LET_O}: r = {1'b1, 8'hF6};
			{MARK_CIRC,  LET_U}: r = {1'b1, 8'hFB};
			{MARK_DIAER, LET_U}: r = {1'b1, 8'hFC};
			{MARK_CEDIL, LET_C}: r = {1'b1, 8'hE7};
			default:             r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

>>> design/videotex_diacritic_decoder.sv
`timescale 1ns / 1ps

// path: a taken byte is held in the input stage, then decoded into the queue;
//   results leave the queue head one per cycle while the receiver is ready
// throughput: one byte per cycle while each byte yields one result and the
//   receiver is ready; set by the queue, which hands out one result per cycle
// reset: arst_n clears the held escape state, the input stage and the queue

module videotex_diacritic_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // in_byte
	input  logic       s_axis_tlast,   // in_last
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // out_byte
	output logic       m_axis_tuser,   // run_last
	output logic       m_axis_tlast    // text_end
);
	import vdd_pkg::*;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// escape state
	logic [1:0] hc_q;
	logic [7:0] hl_q;

	// result queue, head at entry 0
	res_t             q_q [QDEPTH];
	logic [CNT_W-1:0] cnt_q;

	logic advance;
	logic pop;
	logic in_xfer;

	// per-byte results
	logic [1:0]       hc_d;
	logic [7:0]       hl_d;
	logic [RES_W-1:0] n_d;
	res_t             res [RES_MAX];

	// queue room for a worst-case byte, independent of the output side
	assign advance       = valid_s1 && (cnt_q <= CNT_W'(1));
	assign s_axis_tready = !valid_s1 || advance;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = (cnt_q != '0);
	assign pop           = m_axis_tvalid && m_axis_tready;
	assign m_axis_tdata  = q_q[0].out_byte;
	assign m_axis_tuser  = q_q[0].run_last;
	assign m_axis_tlast  = q_q[0].text_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// decode one byte against the held escape
	always_comb begin
		logic [1:0]       hc;
		logic [7:0]       hl;
		logic [RES_W-1:0] n;
		logic [7:0]       rb [RES_MAX];
		logic [8:0]       look;
		hc   = (hc_q == HELD_BAD) ? HELD_NONE : hc_q;
		hl   = hl_q;
		n    = '0;
		look = accent_lookup(hl_q, byte_s1);
		for (int k = 0; k < RES_MAX; k++) begin
			rb[k] = 8'd0;
		end
		if (hc == HELD_MARK) begin
			if (look[8]) begin
				rb[0] = look[7:0];
				n     = RES_W'(1);
				hc    = HELD_NONE;
			end else begin
				// failed match: emit escape, replay the mark and the new byte
				rb[0] = ESC_BYTE;
				n     = RES_W'(1);
				hc    = HELD_NONE;
				if (hl == ESC_BYTE) begin
					hc = HELD_ESC;
				end else begin
					rb[n[1:0]] = hl;
					n          = n + RES_W'(1);
				end
				if (hc == HELD_NONE) begin
					if (byte_s1 == ESC_BYTE) begin
						hc = HELD_ESC;
					end else begin
						rb[n[1:0]] = byte_s1;
						n          = n + RES_W'(1);
					end
				end else begin
					hl = byte_s1;
					hc = HELD_MARK;
				end
			end
		end else if (hc == HELD_NONE) begin
			if (byte_s1 == ESC_BYTE) begin
				hc = HELD_ESC;
			end else begin
				rb[0] = byte_s1;
				n     = RES_W'(1);
			end
		end else begin
			hl = byte_s1;
			hc = HELD_MARK;
		end
		// end of text flushes whatever is held
		if (last_s1) begin
			if (hc != HELD_NONE) begin
				rb[n[1:0]] = ESC_BYTE;
				n          = n + RES_W'(1);
			end
			if (hc == HELD_MARK) begin
				rb[n[1:0]] = hl;
				n          = n + RES_W'(1);
			end
			hc = HELD_NONE;
			hl = 8'd0;
		end
		for (int k = 0; k < RES_MAX; k++) begin
			res[k].out_byte = rb[k];
			res[k].run_last = (RES_W'(k + 1) == n);
			res[k].text_end = last_s1 && (RES_W'(k + 1) == n);
		end
		hc_d = hc;
		hl_d = hl;
		n_d  = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hc_q <= HELD_NONE;
			hl_q <= 8'd0;
		end else if (advance) begin
			hc_q <= hc_d;
			hl_q <= hl_d;
		end
	end

	// queue: shift out at the head, append new results behind what stays
	logic [CNT_W-1:0] base;
	logic [CNT_W-1:0] push_n;
	res_t             q_d [QDEPTH];

	assign base   = cnt_q - CNT_W'(pop);
	assign push_n = advance ? CNT_W'(n_d) : '0;

	always_comb begin
		res_t             sh;
		logic [CNT_W-1:0] off;
		for (int i = 0; i < QDEPTH; i++) begin
			sh  = (pop && (i < QDEPTH - 1)) ? q_q[(i + 1) % QDEPTH] : q_q[i];
			off = CNT_W'(i) - base;
			if (CNT_W'(i) < base) begin
				q_d[i] = sh;
			end else if (off < push_n) begin
				q_d[i] = (off == CNT_W'(0)) ? res[0] :
					(off == CNT_W'(1)) ? res[1] : res[2];
			end else begin
				q_d[i] = sh;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < QDEPTH; i++) begin
			q_q[i] <= q_d[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= base + push_n;
		end
	end

	// checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(QDEPTH))
		else $error("result queue overfilled");

	a_held_code: assert property (@(posedge clk) disable iff (!arst_n)
		hc_q != HELD_BAD)
		else $error("illegal held count");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> hc_q == HELD_NONE && hl_q == 8'd0)
		else $error("held bytes survive end of text");

	a_end_is_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
		else $error("text end not on last result of its byte");

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	import vdd_pkg::*;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;   // in_byte
	logic       s_axis_tlast = 1'b0;    // in_last
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;           // out_byte
	logic       m_axis_tuser;           // run_last
	logic       m_axis_tlast;           // text_end

	// decoded bytes still owed by the block, oldest first
	res_t       latin_q[$];
	// bytes produced by the byte being decoded right now
	logic [7:0] burst_q[$];

	// shadow of the escape held inside the block
	logic [1:0] shadow_cnt = HELD_NONE;
	logic [7:0] shadow_mark = 8'h00;

	int err_count = 0;
	int idle_pct = 0;     // chance of each sender gap, in percent
	int stall_pct = 0;    // chance of a receiver stall, in percent
	int hold_req = 0;     // long receiver hold-off requested by a test

	videotex_diacritic_decoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// hard stop well past the slowest legal run
	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// accent table as {mark, base letter, latin-1 code}
	function automatic logic [23:0] accent_entry(input int idx);
		case (idx)
			0:       return {8'h41, 8'h61, 8'hE0};
			1:       return {8'h43, 8'h61, 8'hE2};
			2:       return {8'h48, 8'h61, 8'hE4};
			3:       return {8'h41, 8'h65, 8'hE8};
			4:       return {8'h42, 8'h65, 8'hE9};
			5:       return {8'h43, 8'h65, 8'hEA};
			6:       return {8'h48, 8'h65, 8'hEB};
			7:       return {8'h43, 8'h69, 8'hEE};
			8:       return {8'h48, 8'h69, 8'hEF};
			9:       return {8'h43, 8'h6F, 8'hF4};
			10:      return {8'h48, 8'h6F, 8'hF6};
			11:      return {8'h43, 8'h75, 8'hFB};
			12:      return {8'h48, 8'h75, 8'hFC};
			default: return {8'h4B, 8'h63, 8'hE7};
		endcase
	endfunction

	// {hit, code} for a held mark followed by a letter
	function automatic logic [8:0] accent_match(input logic [7:0] mark,
		input logic [7:0] letter);
		logic [23:0] ent;
		for (int i = 0; i < 14; i++) begin
			ent = accent_entry(i);
			if (ent[23:16] == mark && ent[15:8] == letter)
				return {1'b1, ent[7:0]};
		end
		return 9'd0;
	endfunction

	// one byte with at most a lone escape held
	task automatic take_plain(input logic [7:0] b);
		if (shadow_cnt == HELD_NONE) begin
			if (b == ESC_BYTE)
				shadow_cnt = HELD_ESC;
			else
				burst_q.push_back(b);
		end else begin
			shadow_mark = b;
			shadow_cnt = HELD_MARK;
		end
	endtask

	// works out the latin-1 bytes that one accepted byte releases
	task automatic decode_byte(input logic [7:0] b, input logic last);
		logic [8:0] hit;
		logic [7:0] mark;
		res_t       r;
		burst_q.delete();
		if (shadow_cnt == HELD_BAD)
			shadow_cnt = HELD_NONE;
		if (shadow_cnt == HELD_MARK) begin
			hit = accent_match(shadow_mark, b);
			shadow_cnt = HELD_NONE;
			if (hit[8]) begin
				burst_q.push_back(hit[7:0]);
			end else begin
				// failed escape: emit it and replay the held mark and the new byte
				mark = shadow_mark;
				burst_q.push_back(ESC_BYTE);
				take_plain(mark);
				take_plain(b);
			end
		end else begin
			take_plain(b);
		end
		if (last) begin
			// end of text flushes whatever is held, unchanged
			if (shadow_cnt != HELD_NONE)
				burst_q.push_back(ESC_BYTE);
			if (shadow_cnt == HELD_MARK)
				burst_q.push_back(shadow_mark);
			shadow_cnt = HELD_NONE;
			shadow_mark = 8'h00;
		end
		for (int k = 0; k < burst_q.size(); k++) begin
			r.out_byte = burst_q[k];
			r.run_last = (k == burst_q.size() - 1);
			r.text_end = last && (k == burst_q.size() - 1);
			latin_q.push_back(r);
		end
	endtask

	task automatic report_mismatch(input string what, input logic [7:0] got,
		input logic [7:0] want);
		$display("%0t ns: %s: got %02h, expected %02h", $time, what, got, want);
		err_count++;
	endtask

	// input side: every accepted byte feeds the shadow decoder
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			decode_byte(s_axis_tdata, s_axis_tlast);
	end

	// output side: every accepted transfer against the oldest expectation
	always @(posedge clk) begin
		res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (latin_q.size() == 0) begin
				report_mismatch("unexpected transfer", m_axis_tdata, 8'h00);
			end else begin
				want = latin_q.pop_front();
				if (m_axis_tdata !== want.out_byte)
					report_mismatch("out_byte", m_axis_tdata, want.out_byte);
				if (m_axis_tuser !== want.run_last)
					report_mismatch("run_last", 8'(m_axis_tuser), 8'(want.run_last));
				if (m_axis_tlast !== want.text_end)
					report_mismatch("text_end", 8'(m_axis_tlast), 8'(want.text_end));
			end
		end
	end

	// receiver: random stalls, or a long hold-off counted here
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	// offers one byte, with random gaps first, and returns once it is taken
	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(0, 99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= last;
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (latin_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// random end-of-text flag, set on roughly one byte in twelve
	function automatic logic rand_last();
		return ($urandom_range(0, 11) == 0);
	endfunction

	function automatic logic [7:0] rand_mark();
		case ($urandom_range(0, 5))
			0:       return MARK_GRAVE;
			1:       return MARK_ACUTE;
			2:       return MARK_CIRC;
			3:       return MARK_DIAER;
			4:       return MARK_CEDIL;
			default: return ESC_BYTE;
		endcase
	endfunction

	function automatic logic [7:0] rand_letter();
		case ($urandom_range(0, 7))
			0:       return LET_A;
			1:       return LET_C;
			2:       return LET_E;
			3:       return LET_I;
			4:       return LET_O;
			5:       return LET_U;
			6:       return ESC_BYTE;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic test_directed_bytes();
		idle_pct = 0;
		stall_pct = 0;
		// byte extremes pass straight through
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		// accent hits, grave over a and cedilla over c
		send_byte(ESC_BYTE, 1'b0);
		send_byte(MARK_GRAVE, 1'b0);
		send_byte(LET_A, 1'b0);
		send_byte(ESC_BYTE, 1'b0);
		send_byte(MARK_CEDIL, 1'b0);
		send_byte(LET_C, 1'b0);
		// acute over a is not in the table: escape and both bytes come out
		send_byte(ESC_BYTE, 1'b0);
		send_byte(MARK_ACUTE, 1'b0);
		send_byte(LET_A, 1'b0);
		// a held escape as the mark restarts a new escape
		send_byte(ESC_BYTE, 1'b0);
		send_byte(ESC_BYTE, 1'b0);
		send_byte(MARK_CIRC, 1'b0);
		send_byte(LET_E, 1'b0);
		// end of text with a lone escape held
		send_byte(ESC_BYTE, 1'b1);
		// end of text with escape and mark held
		send_byte(ESC_BYTE, 1'b0);
		send_byte(MARK_DIAER, 1'b1);
		// failed match on the last byte of the text
		send_byte(ESC_BYTE, 1'b0);
		send_byte(MARK_CIRC, 1'b0);
		send_byte(8'h7A, 1'b1);
		// zero byte is ordinary, even as the last one
		send_byte(8'h00, 1'b1);
		wait_drained();
	endtask

	// well-formed escapes on 45 of 100 picks, the rest random escapes, lone escapes and noise
	task automatic test_random_text(input int n_items, input int idle, input int stall);
		int          sent;
		int          pick;
		logic [23:0] ent;
		idle_pct = idle;
		stall_pct = stall;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				ent = accent_entry($urandom_range(0, 13));
				send_byte(ESC_BYTE, 1'b0);
				send_byte(ent[23:16], 1'b0);
				send_byte(ent[15:8], rand_last());
				sent += 3;
			end else if (pick < 65) begin
				send_byte(ESC_BYTE, rand_last());
				send_byte(rand_mark(), rand_last());
				send_byte(rand_letter(), rand_last());
				sent += 3;
			end else if (pick < 75) begin
				send_byte(ESC_BYTE, rand_last());
				sent++;
			end else begin
				send_byte(8'($urandom_range(0, 255)), rand_last());
				sent++;
			end
		end
		wait_drained();
	endtask

	// receiver holds off while the sender keeps offering, so the block backs up
	task automatic test_backpressure();
		idle_pct = 0;
		stall_pct = 0;
		hold_req = 120;
		for (int i = 0; i < 30; i++)
			send_byte(8'($urandom_range(0, 255)), (i == 29));
		wait_drained();
	endtask

	// sender stops until every result is out, then resumes mid-escape
	task automatic test_drain_pause();
		idle_pct = 20;
		stall_pct = 30;
		send_byte(ESC_BYTE, 1'b0);
		send_byte(MARK_CIRC, 1'b0);
		send_byte(8'h41, 1'b0);
		wait_drained();
		send_byte(ESC_BYTE, 1'b0);
		send_byte(MARK_DIAER, 1'b0);
		wait_drained();
		send_byte(LET_U, 1'b0);
		send_byte(ESC_BYTE, 1'b0);
		wait_drained();
		send_byte(MARK_GRAVE, 1'b0);
		send_byte(LET_E, 1'b1);
		wait_drained();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_bytes();
		test_random_text(20, 0, 0);
		test_random_text(20, 68, 0);
		test_random_text(20, 0, 68);
		test_random_text(20, 37, 37);
		test_backpressure();
		test_drain_pause();
		// close any open text so nothing stays held in the block
		idle_pct = 0;
		stall_pct = 0;
		send_byte(8'h2E, 1'b1);
		wait_drained();
		repeat (20) @(posedge clk);
		while (latin_q.size() != 0) begin
			res_t left;
			left = latin_q.pop_front();
			report_mismatch("missing transfer", 8'h00, left.out_byte);
		end
		if (err_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
